// ===== sv/dcq_pkg.sv =====
`default_nettype none
package dcq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;

  typedef enum logic [1:0] {
    OPC_PUSH        = 2'd0,
    OPC_PUSH_UNIQUE = 2'd1,
    OPC_DRAIN       = 2'd2,
    OPC_CLEAR       = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SCAN,
    ST_DRAIN,
    ST_EMPTY,
    ST_CLEAR
  } state_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_PUSH_ACK,
    EMIT_REFUSE,
    EMIT_CLEAR_ACK,
    EMIT_EMPTY,
    EMIT_ENTRY
  } emit_t;

  typedef struct packed {
    logic [DATA_W-1:0] op;
    logic [DATA_W-1:0] arg0;
    logic [DATA_W-1:0] arg1;
    logic [DATA_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic  load;
    logic  idx_clr;
    logic  scan_en;
    emit_t emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic rd_vld;
    logic match;
    logic last;
  } ctrl_sts_t;

endpackage
`default_nettype wire

// ===== sv/dcq_ctrl.sv =====
`default_nettype none
module dcq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [1:0]       opcode,
  input  dcq_pkg::ctrl_sts_t    sts,
  output dcq_pkg::ctrl_cmd_t    cmd,
  output logic                  busy
);
  import dcq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.idx_clr = 1'b0;
    cmd.scan_en = 1'b0;
    cmd.emit    = EMIT_NONE;
    busy        = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          unique case (opcode_t'(opcode))
            OPC_PUSH:        state_nxt = ST_PUSH;
            OPC_PUSH_UNIQUE: state_nxt = sts.fill_zero ? ST_PUSH : ST_SCAN;
            OPC_DRAIN:       state_nxt = sts.fill_zero ? ST_EMPTY : ST_DRAIN;
            OPC_CLEAR:       state_nxt = ST_CLEAR;
            default:         state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PUSH: begin
        cmd.emit  = EMIT_PUSH_ACK;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        // a hit anywhere refuses the request; otherwise push after the last entry
        priority if (sts.match) begin
          cmd.emit  = EMIT_REFUSE;
          state_nxt = ST_IDLE;
        end else if (sts.last) begin
          state_nxt = ST_PUSH;
        end else begin
          // hold while the next entry is read
          state_nxt = ST_SCAN;
        end
      end
      ST_DRAIN: begin
        cmd.scan_en = 1'b1;
        if (sts.rd_vld) begin
          cmd.emit = EMIT_ENTRY;
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMPTY: begin
        cmd.emit  = EMIT_EMPTY;
        state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd.emit  = EMIT_CLEAR_ACK;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/dcq_datapath.sv =====
`default_nettype none
module dcq_datapath #(
  parameter int DEPTH = dcq_pkg::DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  dcq_pkg::ctrl_cmd_t             cmd,
  output dcq_pkg::ctrl_sts_t             sts,
  input  wire logic [dcq_pkg::DATA_W-1:0] in_cmd_op,
  input  wire logic [dcq_pkg::DATA_W-1:0] in_cmd_arg0,
  input  wire logic [dcq_pkg::DATA_W-1:0] in_cmd_arg1,
  input  wire logic                      in_payload_present,
  input  wire logic [dcq_pkg::DATA_W-1:0] in_payload,
  output logic                           out_valid,
  output logic [1:0]                     out_result_kind,
  output logic                           out_accepted,
  output logic [dcq_pkg::DATA_W-1:0]     out_op,
  output logic [dcq_pkg::DATA_W-1:0]     out_arg0,
  output logic [dcq_pkg::DATA_W-1:0]     out_arg1,
  output logic [dcq_pkg::DATA_W-1:0]     out_payload,
  output logic [CW-1:0]                  out_entry_count,
  output logic                           out_last_of_run
);
  import dcq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t          mem [DEPTH];
  entry_t          req_r;
  entry_t          rd_data_r;
  logic [CW-1:0]   fill_r;
  logic [CW-1:0]   idx_r;
  logic [CW-1:0]   rd_idx_r;
  logic            rd_vld_r;
  logic            full;
  logic            rd_en;

  logic            out_valid_r;
  kind_t           out_kind_r;
  logic            out_acc_r;
  entry_t          out_data_r;
  logic [CW-1:0]   out_count_r;
  logic            out_last_r;

  kind_t           out_kind_nxt;
  logic            out_acc_nxt;
  entry_t          out_data_nxt;
  logic [CW-1:0]   out_count_nxt;
  logic            out_last_nxt;

  assign full  = (fill_r == CW'(DEPTH));
  assign rd_en = cmd.scan_en && (idx_r < fill_r);

  assign sts.fill_zero = (fill_r == '0);
  assign sts.rd_vld    = rd_vld_r;
  assign sts.match     = rd_vld_r && (rd_data_r.op == req_r.op) &&
                         (rd_data_r.arg0 == req_r.arg0) && (rd_data_r.arg1 == req_r.arg1);
  assign sts.last      = rd_vld_r && (CW'(rd_idx_r + 1'b1) == fill_r);

  // latch the request; an absent payload is stored as zero
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r.op      <= in_cmd_op;
      req_r.arg0    <= in_cmd_arg0;
      req_r.arg1    <= in_cmd_arg1;
      req_r.payload <= in_payload_present ? in_payload : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit == EMIT_PUSH_ACK && !full) begin
      mem[fill_r[AW-1:0]] <= req_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
      rd_idx_r  <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.scan_en) begin
        idx_r <= CW'(idx_r + 1'b1);
      end
      if (cmd.emit == EMIT_PUSH_ACK && !full) begin
        fill_r <= CW'(fill_r + 1'b1);
      end else if (cmd.emit == EMIT_CLEAR_ACK ||
                   (cmd.emit == EMIT_ENTRY && sts.last)) begin
        fill_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.emit != EMIT_NONE);
    end
  end

  always_comb begin
    out_kind_nxt  = KIND_ACK;
    out_acc_nxt   = 1'b0;
    out_data_nxt  = '0;
    out_count_nxt = '0;
    out_last_nxt  = 1'b1;
    unique case (cmd.emit)
      EMIT_NONE: begin
      end
      EMIT_PUSH_ACK: begin
        out_acc_nxt   = !full;
        out_count_nxt = full ? fill_r : CW'(fill_r + 1'b1);
      end
      EMIT_REFUSE: begin
        out_count_nxt = fill_r;
      end
      EMIT_CLEAR_ACK: begin
      end
      EMIT_EMPTY: begin
        out_kind_nxt = KIND_EMPTY;
      end
      EMIT_ENTRY: begin
        out_kind_nxt = KIND_ENTRY;
        out_data_nxt = rd_data_r;
        out_last_nxt = sts.last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_acc_r   <= out_acc_nxt;
    out_data_r  <= out_data_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_accepted    = out_acc_r;
  assign out_op          = out_data_r.op;
  assign out_arg0        = out_data_r.arg0;
  assign out_arg1        = out_data_r.arg1;
  assign out_payload     = out_data_r.payload;
  assign out_entry_count = out_count_r;
  assign out_last_of_run = out_last_r;

endmodule
`default_nettype wire

// ===== sv/dedup_command_queue_core.sv =====
`default_nettype none
// channel   | handshake            | fields
// ----------+----------------------+--------------------------------------------------
// request   | start / busy         | in_opcode, in_cmd_op, in_cmd_arg0, in_cmd_arg1,
//           |                      | in_payload_present, in_payload
// result    | out_valid (1 cycle)  | out_result_kind, out_accepted, out_op, out_arg0,
//           |                      | out_arg1, out_payload, out_entry_count,
//           |                      | out_last_of_run
//
// A request is taken when start is high and busy low; each result is registered
// and shows the cycle after the controller issues it. Push, clear and any request
// on an empty queue issue their result and go back to idle; push if not queued
// reads one stored entry a cycle from the single read port, and a hit on an entry
// ends it with a refusal; drain emits one entry a cycle.
// Reset is synchronous and empties the queue; entry storage is not cleared.
// Results are strobed for one cycle and cannot be stalled.
module dedup_command_queue_core #(
  parameter int DEPTH = dcq_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_opcode,
  input  wire logic [dcq_pkg::DATA_W-1:0]    in_cmd_op,
  input  wire logic [dcq_pkg::DATA_W-1:0]    in_cmd_arg0,
  input  wire logic [dcq_pkg::DATA_W-1:0]    in_cmd_arg1,
  input  wire logic                          in_payload_present,
  input  wire logic [dcq_pkg::DATA_W-1:0]    in_payload,
  output logic                               out_valid,
  output logic [1:0]                         out_result_kind,
  output logic                               out_accepted,
  output logic [dcq_pkg::DATA_W-1:0]         out_op,
  output logic [dcq_pkg::DATA_W-1:0]         out_arg0,
  output logic [dcq_pkg::DATA_W-1:0]         out_arg1,
  output logic [dcq_pkg::DATA_W-1:0]         out_payload,
  output logic [$clog2(DEPTH+1)-1:0]         out_entry_count,
  output logic                               out_last_of_run
);
  import dcq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  dcq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  dcq_datapath #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_cmd_op          (in_cmd_op),
    .in_cmd_arg0        (in_cmd_arg0),
    .in_cmd_arg1        (in_cmd_arg1),
    .in_payload_present (in_payload_present),
    .in_payload         (in_payload),
    .out_valid          (out_valid),
    .out_result_kind    (out_result_kind),
    .out_accepted       (out_accepted),
    .out_op             (out_op),
    .out_arg0           (out_arg0),
    .out_arg1           (out_arg1),
    .out_payload        (out_payload),
    .out_entry_count    (out_entry_count),
    .out_last_of_run    (out_last_of_run)
  );

endmodule
`default_nettype wire

// ===== sv/dcq_checker.sv =====
`default_nettype none
module dcq_checker #(
  parameter int DEPTH = dcq_pkg::DEPTH_DEF
) (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      out_valid,
  input wire logic [1:0]                out_result_kind,
  input wire logic                      out_accepted,
  input wire logic [$clog2(DEPTH+1)-1:0] out_entry_count,
  input wire logic                      out_last_of_run
);
  import dcq_pkg::*;

  // an accepted request always leaves the block busy in the cycle after it is taken
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // drained entries are never push acknowledgements and carry a zero entry count
  a_entry_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_ENTRY) |-> !out_accepted && (out_entry_count == '0))
    else $error("drained entry with accepted flag or non-zero count");

  // a drain run is unbroken until its last entry
  a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |=> out_valid && (out_result_kind == KIND_ENTRY))
    else $error("drain run broken before its last entry");

  // the end of a run leaves a gap before the next request's result
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |=> !out_valid)
    else $error("result directly after end of run");

  a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_EMPTY) |-> out_last_of_run)
    else $error("empty-queue marker not last of run");

endmodule

bind dedup_command_queue_core dcq_checker #(.DEPTH(DEPTH)) u_dcq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_result_kind (out_result_kind),
  .out_accepted    (out_accepted),
  .out_entry_count (out_entry_count),
  .out_last_of_run (out_last_of_run)
);
`default_nettype wire

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dcq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int ITEM_TARGET = 310;

  typedef struct packed {
    logic [1:0]        kind;
    logic              accepted;
    logic [DATA_W-1:0] op;
    logic [DATA_W-1:0] arg0;
    logic [DATA_W-1:0] arg1;
    logic [DATA_W-1:0] payload;
    logic [CNT_W-1:0]  count;
    logic              last;
  } queue_reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_opcode = OPC_PUSH;
  logic [DATA_W-1:0] in_cmd_op = '0;
  logic [DATA_W-1:0] in_cmd_arg0 = '0;
  logic [DATA_W-1:0] in_cmd_arg1 = '0;
  logic              in_payload_present = 1'b0;
  logic [DATA_W-1:0] in_payload = '0;
  logic              out_valid;
  logic [1:0]        out_result_kind;
  logic              out_accepted;
  logic [DATA_W-1:0] out_op;
  logic [DATA_W-1:0] out_arg0;
  logic [DATA_W-1:0] out_arg1;
  logic [DATA_W-1:0] out_payload;
  logic [CNT_W-1:0]  out_entry_count;
  logic              out_last_of_run;

  queue_reply_t pending_replies[$];
  entry_t       stored_entries[$];
  queue_reply_t seen_reply;
  int           error_count = 0;
  int           requests_sent = 0;
  bit           fast_sender = 1'b0;

  dedup_command_queue_core #(.DEPTH(DEPTH)) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_cmd_op          (in_cmd_op),
    .in_cmd_arg0        (in_cmd_arg0),
    .in_cmd_arg1        (in_cmd_arg1),
    .in_payload_present (in_payload_present),
    .in_payload         (in_payload),
    .out_valid          (out_valid),
    .out_result_kind    (out_result_kind),
    .out_accepted       (out_accepted),
    .out_op             (out_op),
    .out_arg0           (out_arg0),
    .out_arg1           (out_arg1),
    .out_payload        (out_payload),
    .out_entry_count    (out_entry_count),
    .out_last_of_run    (out_last_of_run)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Queue model: work out the replies one request produces and update the store
  task automatic model_request(opcode_t opc, logic [DATA_W-1:0] op, logic [DATA_W-1:0] a0,
                               logic [DATA_W-1:0] a1, logic present,
                               logic [DATA_W-1:0] pl);
    queue_reply_t r;
    entry_t       e;
    bit           dup;
    r   = '0;
    dup = 1'b0;
    case (opc)
      OPC_PUSH, OPC_PUSH_UNIQUE: begin
        if (opc == OPC_PUSH_UNIQUE) begin
          foreach (stored_entries[i]) begin
            if (stored_entries[i].op == op && stored_entries[i].arg0 == a0 &&
                stored_entries[i].arg1 == a1)
              dup = 1'b1;
          end
        end
        if (!dup && stored_entries.size() < DEPTH) begin
          e.op      = op;
          e.arg0    = a0;
          e.arg1    = a1;
          e.payload = present ? pl : '0;
          stored_entries.push_back(e);
          r.accepted = 1'b1;
        end
        r.kind  = KIND_ACK;
        r.count = CNT_W'(stored_entries.size());
        r.last  = 1'b1;
        pending_replies.push_back(r);
      end
      OPC_DRAIN: begin
        if (stored_entries.size() == 0) begin
          r.kind = KIND_EMPTY;
          r.last = 1'b1;
          pending_replies.push_back(r);
        end else begin
          foreach (stored_entries[i]) begin
            r.kind    = KIND_ENTRY;
            r.op      = stored_entries[i].op;
            r.arg0    = stored_entries[i].arg0;
            r.arg1    = stored_entries[i].arg1;
            r.payload = stored_entries[i].payload;
            r.last    = (i == stored_entries.size() - 1);
            pending_replies.push_back(r);
          end
        end
        stored_entries.delete();
      end
      default: begin
        stored_entries.delete();
        r.kind = KIND_ACK;
        r.last = 1'b1;
        pending_replies.push_back(r);
      end
    endcase
  endtask

  // Drive one request and hold it until the queue takes it
  task automatic send_request(opcode_t opc, logic [DATA_W-1:0] op, logic [DATA_W-1:0] a0,
                              logic [DATA_W-1:0] a1, logic present,
                              logic [DATA_W-1:0] pl);
    int gap;
    gap = fast_sender ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start              <= 1'b1;
    in_opcode          <= opc;
    in_cmd_op          <= op;
    in_cmd_arg0        <= a0;
    in_cmd_arg1        <= a1;
    in_payload_present <= present;
    in_payload         <= pl;
    @(posedge clk);
    while (busy) @(posedge clk);
    model_request(opc, op, a0, a1, present, pl);
    requests_sent++;
  endtask

  task automatic wait_for_idle();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Reuse a stored key half the time so that duplicates are hit often
  task automatic choose_key(output logic [DATA_W-1:0] op, output logic [DATA_W-1:0] a0,
                            output logic [DATA_W-1:0] a1);
    entry_t e;
    if (stored_entries.size() > 0 && $urandom_range(0, 1) == 1) begin
      e  = stored_entries[$urandom_range(0, stored_entries.size() - 1)];
      op = e.op;
      a0 = e.arg0;
      a1 = e.arg1;
      case ($urandom_range(0, 5))
        0:       op = pick_word();
        1:       a0 = pick_word();
        2:       a1 = pick_word();
        default: ;
      endcase
    end else begin
      op = pick_word();
      a0 = pick_word();
      a1 = pick_word();
    end
  endtask

  task automatic compare_field(string name, logic [DATA_W-1:0] exp_val,
                               logic [DATA_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, exp_val,
               act_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $display("%0t ns: unexpected reply: expected none, actual kind %0d op %h",
                 $time, out_result_kind, out_op);
        error_count++;
      end else begin
        seen_reply = pending_replies.pop_front();
        compare_field("result_kind", DATA_W'(seen_reply.kind), DATA_W'(out_result_kind));
        compare_field("accepted", DATA_W'(seen_reply.accepted), DATA_W'(out_accepted));
        compare_field("op", seen_reply.op, out_op);
        compare_field("arg0", seen_reply.arg0, out_arg0);
        compare_field("arg1", seen_reply.arg1, out_arg1);
        compare_field("payload", seen_reply.payload, out_payload);
        compare_field("entry_count", DATA_W'(seen_reply.count), DATA_W'(out_entry_count));
        compare_field("last_of_run", DATA_W'(seen_reply.last), DATA_W'(out_last_of_run));
      end
    end
  end

  task automatic test_basic_commands();
    send_request(OPC_DRAIN, '0, '0, '0, 1'b0, '0);
    send_request(OPC_PUSH, '1, '1, '1, 1'b1, '1);
    // absent payload must be stored as zero
    send_request(OPC_PUSH, 32'd1, 32'd2, 32'd3, 1'b0, '1);
    send_request(OPC_PUSH_UNIQUE, '0, '0, '0, 1'b1, 32'h5a5a_5a5a);
    // payload takes no part in the duplicate match
    send_request(OPC_PUSH_UNIQUE, '1, '1, '1, 1'b1, 32'h0000_0001);
    send_request(OPC_PUSH_UNIQUE, '1, '1, 32'hffff_fffe, 1'b1, 32'ha5a5_a5a5);
    wait_for_idle();
    send_request(OPC_DRAIN, '0, '0, '0, 1'b1, '1);
    send_request(OPC_CLEAR, '1, '1, '1, 1'b1, '1);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < DEPTH - 1; i++)
      send_request(OPC_PUSH, i, $urandom(), $urandom(), i[0], $urandom());
    send_request(OPC_PUSH_UNIQUE, 32'hdead_0000, '0, '1, 1'b1, 32'h1234_5678);
    // refuse both kinds of push once full
    send_request(OPC_PUSH, $urandom(), $urandom(), $urandom(), 1'b1, $urandom());
    send_request(OPC_PUSH_UNIQUE, 32'hbeef_0000, $urandom(), $urandom(), 1'b0, '0);
    send_request(OPC_DRAIN, '0, '0, '0, 1'b0, '0);
  endtask

  task automatic test_random_traffic();
    int                burst;
    opcode_t           opc;
    logic [DATA_W-1:0] op;
    logic [DATA_W-1:0] a0;
    logic [DATA_W-1:0] a1;
    while (requests_sent < ITEM_TARGET) begin
      fast_sender = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(0, DEPTH + 4);
      repeat (burst) begin
        if ($urandom_range(0, 15) == 0) begin
          // stray drain or clear in the middle of a burst
          opc = $urandom_range(0, 1) ? OPC_DRAIN : OPC_CLEAR;
          send_request(opc, pick_word(), pick_word(), pick_word(), 1'($urandom_range(0, 1)),
                       pick_word());
        end else begin
          opc = $urandom_range(0, 1) ? OPC_PUSH_UNIQUE : OPC_PUSH;
          choose_key(op, a0, a1);
          send_request(opc, op, a0, a1, 1'($urandom_range(0, 1)), pick_word());
        end
      end
      if ($urandom_range(0, 3) == 0) wait_for_idle();
      opc = ($urandom_range(0, 3) == 0) ? OPC_CLEAR : OPC_DRAIN;
      send_request(opc, pick_word(), pick_word(), pick_word(), 1'($urandom_range(0, 1)),
                   pick_word());
    end
    fast_sender = 1'b0;
  endtask

  initial begin
    int guard;
    guard = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_commands();
    test_full_queue();
    test_random_traffic();
    start <= 1'b0;
    while (pending_replies.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_replies.size() != 0) begin
      $display("%0t ns: %0d replies never arrived", $time, pending_replies.size());
      error_count++;
    end
    repeat (DEPTH + 8) @(posedge clk);
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #1ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
sv/dcq_pkg.sv
sv/dcq_ctrl.sv
sv/dcq_datapath.sv
sv/dedup_command_queue_core.sv
sv/dcq_checker.sv
verif/testbench.sv
